FILE: src/assert_macros.svh
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CCP_ASSERT_NEVER(lbl, clk, rst, cond) \
  `CCP_ASSERT(lbl, clk, rst, !(cond))
`else
`define CCP_ASSERT(lbl, clk, rst, prop)
`define CCP_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: src/ccp_pkg.sv
// Types and constants of the convex polygon clipper.
`timescale 1ns / 1ps
`default_nettype none
package ccp_pkg;
  localparam int MA_W   = 45;  // multiplier operand a, also divisor
  localparam int MB_W   = 26;  // multiplier operand b
  localparam int PR_W   = 71;  // product
  localparam int NM_W   = 72;  // dividend
  localparam int SIDE_W = 43;  // turn test value
  localparam int Q_W    = 24;

  localparam logic KIND_CLIP    = 1'b0;
  localparam logic KIND_SUBJECT = 1'b1;

  localparam logic [Q_W:0] Q_POS_MAG = 25'd8388607;
  localparam logic [Q_W:0] Q_NEG_MAG = 25'd8388608;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               final_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] ox;
    logic signed [23:0] oy;
    logic               end_of_polygon;
    logic               empty_result;
    logic               overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LD_E0, DP_LD_E1, DP_LD_P, DP_SIDE_M1, DP_SIDE_M2, DP_SIDE_END,
    DP_ADVANCE, DP_X_M1, DP_X_M2, DP_X_DIV, DP_X_END
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   coord_y;
    logic   clip_we;
    logic   buf_we;
    logic   wr_b;
    logic   rd_b;
    logic   load_subj;
    logic   push_ip;
    logic   emit;
    logic   emit_empty;
    logic   emit_end;
    logic   emit_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic md_busy;
    logic cp_in;
    logic cl_in;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PASS_CHK, ST_E0_LD, ST_E1_LD, ST_LAST_LD, ST_SIDE1, ST_SIDE1_W,
    ST_SIDE2_W, ST_DECIDE, ST_X1, ST_X1_W, ST_X2_W, ST_X3_W, ST_PUSH_IP,
    ST_PUSH_P, ST_NEXT, ST_PT_RD, ST_PT_LD, ST_OUT_CHK, ST_OUT_EMIT
  } ctrl_state_t;
endpackage
`default_nettype wire

FILE: src/ccp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ccp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/ccp_muldiv.sv
// Shared serial multiplier and restoring divider with a saturated Q16.8 quotient.
`timescale 1ns / 1ps
`default_nettype none
module ccp_muldiv import ccp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start_mul,
  input  wire logic                   start_div,
  input  wire logic signed [MA_W-1:0] a,
  input  wire logic signed [MB_W-1:0] b,
  input  wire logic signed [NM_W-1:0] num,
  output logic                        busy,
  output logic signed [PR_W-1:0]      prod,
  output logic signed [Q_W-1:0]       quot
);
  logic [6:0]      cnt;
  logic            div_mode;
  logic            neg;
  logic [PR_W-1:0] acc;
  logic [PR_W-1:0] sa;
  logic [MB_W-1:0] mb;
  logic [NM_W-1:0] nm;
  logic [MA_W-1:0] dm;
  logic [MA_W:0]   rem;
  logic [Q_W:0]    q;
  logic            big;
  logic [MA_W:0]   rem_sh;
  logic            q_bit;

  assign busy   = (cnt != '0);
  assign rem_sh = {rem[MA_W-1:0], nm[NM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dm});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start_mul) begin
      cnt <= 7'(MB_W);
    end else if (start_div) begin
      cnt <= 7'(NM_W);
    end else if (busy) begin
      cnt <= cnt - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_mul) begin
      div_mode <= 1'b0;
      neg      <= a[MA_W-1] ^ b[MB_W-1];
      acc      <= '0;
      sa       <= PR_W'(a[MA_W-1] ? -a : a);
      mb       <= b[MB_W-1] ? -b : b;
    end else if (start_div) begin
      div_mode <= 1'b1;
      neg      <= num[NM_W-1] ^ a[MA_W-1];
      nm       <= num[NM_W-1] ? -num : num;
      dm       <= a[MA_W-1] ? -a : a;
      rem      <= '0;
      q        <= '0;
      big      <= 1'b0;
    end else if (busy) begin
      if (div_mode) begin
        rem <= q_bit ? rem_sh - {1'b0, dm} : rem_sh;
        nm  <= {nm[NM_W-2:0], 1'b0};
        q   <= {q[Q_W-1:0], q_bit};
        big <= big | q[Q_W];
      end else begin
        if (mb[0]) begin
          acc <= acc + sa;
        end
        sa <= {sa[PR_W-2:0], 1'b0};
        mb <= {1'b0, mb[MB_W-1:1]};
      end
    end
  end

  assign prod = neg ? -$signed(acc) : $signed(acc);

  always_comb begin
    if (neg) begin
      quot = (big || q > Q_NEG_MAG) ? {1'b1, {(Q_W-1){1'b0}}} : -$signed(q[Q_W-1:0]);
    end else begin
      quot = (big || q > Q_POS_MAG) ? {1'b0, {(Q_W-1){1'b1}}} : $signed(q[Q_W-1:0]);
    end
  end
endmodule
`default_nettype wire

FILE: src/ccp_datapath.sv
// Clipper datapath: vertex stores, turn test, edge crossing and result register.
`timescale 1ns / 1ps
`default_nettype none
module ccp_datapath import ccp_pkg::*; #(
  parameter int MAX_CLIP_VERTS    = 16,
  parameter int MAX_SUBJECT_VERTS = 16,
  parameter int WORK_CAP          = MAX_CLIP_VERTS + MAX_SUBJECT_VERTS,
  parameter int CA_W              = $clog2(MAX_CLIP_VERTS),
  parameter int BA_W              = $clog2(WORK_CAP)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic signed [15:0] vx,
  input  wire logic signed [15:0] vy,
  input  wire logic [CA_W-1:0]    clip_waddr,
  input  wire logic [CA_W-1:0]    clip_raddr,
  input  wire logic [BA_W-1:0]    buf_waddr,
  input  wire logic [BA_W-1:0]    buf_raddr,
  output out_item_t               result
);
  logic [31:0]              clip_rd;
  logic [2*Q_W-1:0]         rd_a, rd_b, src_rd, buf_wd;
  logic signed [15:0]       e0x, e0y, e1x, e1y;
  logic signed [16:0]       ex, ey;
  logic signed [Q_W-1:0]    px, py, lx, ly, ix, iy;
  logic signed [Q_W-1:0]    e0x_q, e0y_q, base, pk;
  logic signed [Q_W:0]      sdx, sdy, dk;
  logic signed [SIDE_W-1:0] cp, cl;
  logic signed [SIDE_W:0]   den;
  logic signed [PR_W-1:0]   t, prod;
  logic signed [MA_W-1:0]   md_a;
  logic signed [MB_W-1:0]   md_b;
  logic signed [NM_W-1:0]   num;
  logic signed [Q_W-1:0]    quot;
  logic                     start_mul, start_div, md_busy;

  ccp_ram #(.WIDTH(32), .DEPTH(MAX_CLIP_VERTS)) u_clip (
    .clk, .we(cmd.clip_we), .waddr(clip_waddr), .wdata({vx, vy}),
    .raddr(clip_raddr), .rdata(clip_rd));

  ccp_ram #(.WIDTH(2*Q_W), .DEPTH(WORK_CAP)) u_buf_a (
    .clk, .we(cmd.buf_we && !cmd.wr_b), .waddr(buf_waddr), .wdata(buf_wd),
    .raddr(buf_raddr), .rdata(rd_a));

  ccp_ram #(.WIDTH(2*Q_W), .DEPTH(WORK_CAP)) u_buf_b (
    .clk, .we(cmd.buf_we && cmd.wr_b), .waddr(buf_waddr), .wdata(buf_wd),
    .raddr(buf_raddr), .rdata(rd_b));

  ccp_muldiv u_md (
    .clk, .rst, .start_mul, .start_div, .a(md_a), .b(md_b), .num,
    .busy(md_busy), .prod, .quot);

  assign src_rd = cmd.rd_b ? rd_b : rd_a;
  assign buf_wd = cmd.load_subj ? {vx, 8'h00, vy, 8'h00}
                : (cmd.push_ip ? {ix, iy} : {px, py});

  assign e0x_q = {e0x, 8'h00};
  assign e0y_q = {e0y, 8'h00};
  assign ex    = 17'(e1x) - 17'(e0x);
  assign ey    = 17'(e1y) - 17'(e0y);
  assign sdx   = 25'(px) - 25'(e0x_q);
  assign sdy   = 25'(py) - 25'(e0y_q);
  assign den   = 44'(cl) - 44'(cp);
  assign base  = cmd.coord_y ? ly : lx;
  assign pk    = cmd.coord_y ? py : px;
  assign dk    = 25'(pk) - 25'(base);
  assign num   = 72'(t) + 72'(prod);

  always_comb begin
    md_a      = '0;
    md_b      = '0;
    start_mul = 1'b0;
    start_div = 1'b0;
    unique case (cmd.op)
      DP_SIDE_M1: begin md_a = 45'(ey);  md_b = 26'(sdx);  start_mul = 1'b1; end
      DP_SIDE_M2: begin md_a = 45'(ex);  md_b = 26'(sdy);  start_mul = 1'b1; end
      DP_X_M1:    begin md_a = 45'(den); md_b = 26'(base); start_mul = 1'b1; end
      DP_X_M2:    begin md_a = 45'(cl);  md_b = 26'(dk);   start_mul = 1'b1; end
      DP_X_DIV:   begin md_a = 45'(den); start_div = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LD_E0:    begin e0x <= clip_rd[31:16]; e0y <= clip_rd[15:0]; end
      DP_LD_E1:    begin e1x <= clip_rd[31:16]; e1y <= clip_rd[15:0]; end
      DP_LD_P:     begin px <= src_rd[2*Q_W-1:Q_W]; py <= src_rd[Q_W-1:0]; end
      DP_SIDE_M2:  t <= prod;
      DP_SIDE_END: cp <= SIDE_W'(t - prod);
      DP_ADVANCE:  begin lx <= px; ly <= py; cl <= cp; end
      DP_X_M2:     t <= prod;
      DP_X_END: begin
        if (cmd.coord_y) begin
          iy <= quot;
        end else begin
          ix <= quot;
        end
      end
      default: ;
    endcase
    if (cmd.emit) begin
      result.ox             <= cmd.emit_empty ? '0 : src_rd[2*Q_W-1:Q_W];
      result.oy             <= cmd.emit_empty ? '0 : src_rd[Q_W-1:0];
      result.end_of_polygon <= cmd.emit_end;
      result.empty_result   <= cmd.emit_empty;
      result.overflowed     <= cmd.emit_ovf;
    end
  end

  // A point is inside an edge unless its turn is strictly clockwise.
  assign stat.md_busy = md_busy;
  assign stat.cp_in   = cp[SIDE_W-1] || (cp == '0);
  assign stat.cl_in   = cl[SIDE_W-1] || (cl == '0);
endmodule
`default_nettype wire

FILE: src/ccp_ctrl.sv
// Clipper controller: loading, pass sequencing and result emission.
`timescale 1ns / 1ps
`default_nettype none
module ccp_ctrl import ccp_pkg::*; #(
  parameter int MAX_CLIP_VERTS    = 16,
  parameter int MAX_SUBJECT_VERTS = 16,
  parameter int WORK_CAP          = MAX_CLIP_VERTS + MAX_SUBJECT_VERTS,
  parameter int CA_W              = $clog2(MAX_CLIP_VERTS),
  parameter int BA_W              = $clog2(WORK_CAP)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            kind,
  input  wire logic            final_vertex,
  output logic                 busy,
  output logic                 strobe,
  output dp_cmd_t              cmd,
  input  wire dp_stat_t        stat,
  output logic [CA_W-1:0]      clip_waddr,
  output logic [CA_W-1:0]      clip_raddr,
  output logic [BA_W-1:0]      buf_waddr,
  output logic [BA_W-1:0]      buf_raddr
);
  localparam int CC_W = $clog2(MAX_CLIP_VERTS + 1);
  localparam int SC_W = $clog2(MAX_SUBJECT_VERTS + 1);
  localparam int NW   = $clog2(WORK_CAP + 1);

  ctrl_state_t     state, state_next;
  logic [CC_W-1:0] clip_count, clip_count_next, clip_eff, pass_i, pass_i_next, nx;
  logic            clip_closed, clip_closed_next;
  logic [SC_W-1:0] work_count, work_count_next;
  logic            drop_flag, drop_flag_next;
  logic [NW-1:0]   n, n_next, cnt, cnt_next, j, j_next;
  logic            src_b, src_b_next, first, first_next, k, k_next;
  logic            need_x;

  assign busy     = (state != ST_IDLE);
  assign clip_eff = clip_closed ? '0 : clip_count;
  assign nx       = ((pass_i + CC_W'(1)) < clip_count) ? pass_i + CC_W'(1) : '0;
  assign need_x   = stat.cp_in ? !stat.cl_in : stat.cl_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      clip_count  <= '0;
      clip_closed <= 1'b0;
      work_count  <= '0;
      drop_flag   <= 1'b0;
      n           <= '0;
      cnt         <= '0;
      j           <= '0;
      pass_i      <= '0;
      src_b       <= 1'b0;
      first       <= 1'b0;
      k           <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      clip_count  <= clip_count_next;
      clip_closed <= clip_closed_next;
      work_count  <= work_count_next;
      drop_flag   <= drop_flag_next;
      n           <= n_next;
      cnt         <= cnt_next;
      j           <= j_next;
      pass_i      <= pass_i_next;
      src_b       <= src_b_next;
      first       <= first_next;
      k           <= k_next;
      strobe      <= cmd.emit;
    end
  end

  always_comb begin
    state_next       = state;
    clip_count_next  = clip_count;
    clip_closed_next = clip_closed;
    work_count_next  = work_count;
    drop_flag_next   = drop_flag;
    n_next           = n;
    cnt_next         = cnt;
    j_next           = j;
    pass_i_next      = pass_i;
    src_b_next       = src_b;
    first_next       = first;
    k_next           = k;
    cmd              = '0;
    cmd.op           = DP_NONE;
    cmd.coord_y      = k;
    cmd.rd_b         = src_b;
    cmd.wr_b         = !src_b;
    clip_waddr       = clip_eff[CA_W-1:0];
    clip_raddr       = pass_i[CA_W-1:0];
    buf_waddr        = BA_W'(cnt);
    buf_raddr        = BA_W'(j);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (kind == KIND_CLIP) begin
            clip_closed_next = final_vertex;
            if (clip_eff < CC_W'(MAX_CLIP_VERTS)) begin
              cmd.clip_we     = 1'b1;
              clip_count_next = clip_eff + CC_W'(1);
            end else begin
              clip_count_next = clip_eff;
              drop_flag_next  = 1'b1;
            end
          end else begin
            buf_waddr = BA_W'(work_count);
            cmd.wr_b  = 1'b0;
            if (work_count < SC_W'(MAX_SUBJECT_VERTS)) begin
              cmd.buf_we      = 1'b1;
              cmd.load_subj   = 1'b1;
              work_count_next = work_count + SC_W'(1);
            end else begin
              drop_flag_next = 1'b1;
            end
            if (final_vertex) begin
              n_next      = NW'(work_count_next);
              pass_i_next = '0;
              src_b_next  = 1'b0;
              state_next  = ST_PASS_CHK;
            end
          end
        end
      end
      ST_PASS_CHK: begin
        buf_raddr = '0;
        if (pass_i < clip_count && n != '0) begin
          state_next = ST_E0_LD;
        end else begin
          state_next = ST_OUT_CHK;
        end
      end
      ST_E0_LD: begin
        cmd.op     = DP_LD_E0;
        clip_raddr = nx[CA_W-1:0];
        state_next = ST_E1_LD;
      end
      ST_E1_LD: begin
        cmd.op     = DP_LD_E1;
        buf_raddr  = BA_W'(n - NW'(1));
        state_next = ST_LAST_LD;
      end
      ST_LAST_LD: begin
        cmd.op     = DP_LD_P;
        first_next = 1'b1;
        cnt_next   = '0;
        state_next = ST_SIDE1;
      end
      ST_SIDE1: begin
        cmd.op     = DP_SIDE_M1;
        state_next = ST_SIDE1_W;
      end
      ST_SIDE1_W: begin
        if (!stat.md_busy) begin
          cmd.op     = DP_SIDE_M2;
          state_next = ST_SIDE2_W;
        end
      end
      ST_SIDE2_W: begin
        if (!stat.md_busy) begin
          cmd.op     = DP_SIDE_END;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        k_next = 1'b0;
        if (first) begin
          // The wrap-around vertex becomes the previous point of the pass.
          cmd.op     = DP_ADVANCE;
          first_next = 1'b0;
          j_next     = '0;
          state_next = ST_PT_RD;
        end else if (need_x) begin
          state_next = ST_X1;
        end else if (stat.cp_in) begin
          state_next = ST_PUSH_P;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_X1: begin
        cmd.op     = DP_X_M1;
        state_next = ST_X1_W;
      end
      ST_X1_W: begin
        if (!stat.md_busy) begin
          cmd.op     = DP_X_M2;
          state_next = ST_X2_W;
        end
      end
      ST_X2_W: begin
        if (!stat.md_busy) begin
          cmd.op     = DP_X_DIV;
          state_next = ST_X3_W;
        end
      end
      ST_X3_W: begin
        if (!stat.md_busy) begin
          cmd.op = DP_X_END;
          if (!k) begin
            k_next     = 1'b1;
            state_next = ST_X1;
          end else begin
            state_next = ST_PUSH_IP;
          end
        end
      end
      ST_PUSH_IP, ST_PUSH_P: begin
        cmd.push_ip = (state == ST_PUSH_IP);
        if (cnt < NW'(WORK_CAP)) begin
          cmd.buf_we = 1'b1;
          cnt_next   = cnt + NW'(1);
        end else begin
          drop_flag_next = 1'b1;
        end
        state_next = (state == ST_PUSH_IP && stat.cp_in) ? ST_PUSH_P : ST_NEXT;
      end
      ST_NEXT: begin
        cmd.op = DP_ADVANCE;
        if ((j + NW'(1)) == n) begin
          n_next      = cnt;
          pass_i_next = pass_i + CC_W'(1);
          src_b_next  = !src_b;
          state_next  = ST_PASS_CHK;
        end else begin
          j_next     = j + NW'(1);
          state_next = ST_PT_RD;
        end
      end
      ST_PT_RD: begin
        state_next = ST_PT_LD;
      end
      ST_PT_LD: begin
        cmd.op     = DP_LD_P;
        state_next = ST_SIDE1;
      end
      ST_OUT_CHK: begin
        j_next    = '0;
        buf_raddr = '0;
        if (n == '0) begin
          cmd.emit        = 1'b1;
          cmd.emit_empty  = 1'b1;
          cmd.emit_end    = 1'b1;
          cmd.emit_ovf    = drop_flag;
          work_count_next = '0;
          drop_flag_next  = 1'b0;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_OUT_EMIT;
        end
      end
      ST_OUT_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_end = ((j + NW'(1)) == n);
        cmd.emit_ovf = drop_flag;
        buf_raddr    = BA_W'(j + NW'(1));
        j_next       = j + NW'(1);
        if (cmd.emit_end) begin
          work_count_next = '0;
          drop_flag_next  = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/convex_polygon_clipper.sv
// Top level of the convex polygon clipper.
//
// Input: a vertex transfer happens on a clock edge with start high and busy low.
// kind selects clip polygon or subject polygon; final_vertex closes the polygon.
// Each vertex load leaves busy low, but a final subject vertex
// starts the clipping run, and busy stays high until the last result is out.
// Output: each result vertex is on result for one cycle with strobe high; the
// receiver cannot stall, so the run never waits on the output side.
// Run steps: each clip edge pass fetches the edge and tests the wrap-around vertex,
// then tests each input vertex and writes the kept ones, and computes each edge
// crossing (per coordinate two 26-step serial multiplies and one 72-step restoring
// divide in the shared arithmetic unit).
// After the last pass come the pass check and the output check, then one result
// vertex per cycle; the empty marker is emitted from the output check itself.
// Vertices beyond the store sizes are dropped and reported by overflowed.
// Reset (synchronous, active high) empties both polygons and clears the
// drop flag; vertex stores hold no reset contents.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module convex_polygon_clipper import ccp_pkg::*; #(
  parameter int MAX_CLIP_VERTS    = 16,
  parameter int MAX_SUBJECT_VERTS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t item,
  output logic          strobe,
  output out_item_t     result
);
  localparam int WORK_CAP = MAX_CLIP_VERTS + MAX_SUBJECT_VERTS;
  localparam int CA_W     = $clog2(MAX_CLIP_VERTS);
  localparam int BA_W     = $clog2(WORK_CAP);

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [CA_W-1:0] clip_waddr, clip_raddr;
  logic [BA_W-1:0] buf_waddr, buf_raddr;

  ccp_ctrl #(
    .MAX_CLIP_VERTS(MAX_CLIP_VERTS), .MAX_SUBJECT_VERTS(MAX_SUBJECT_VERTS)
  ) u_ctrl (
    .clk, .rst, .start, .kind(item.kind), .final_vertex(item.final_vertex),
    .busy, .strobe, .cmd, .stat, .clip_waddr, .clip_raddr, .buf_waddr, .buf_raddr);

  ccp_datapath #(
    .MAX_CLIP_VERTS(MAX_CLIP_VERTS), .MAX_SUBJECT_VERTS(MAX_SUBJECT_VERTS)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .vx(item.vx), .vy(item.vy),
    .clip_waddr, .clip_raddr, .buf_waddr, .buf_raddr, .result);

  `CCP_ASSERT(a_strobe_in_run, clk, rst, strobe |-> $past(busy))
  `CCP_ASSERT(a_empty_is_last, clk, rst, (strobe && result.empty_result) |-> result.end_of_polygon)
  `CCP_ASSERT_NEVER(a_empty_zero, clk, rst, strobe && result.empty_result && (result.ox != 0 || result.oy != 0))
  `CCP_ASSERT(a_clip_load_idle, clk, rst, (start && !busy && item.kind == KIND_CLIP) |=> !busy)
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the convex polygon clipper.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ccp_pkg::*;

  localparam int CLIP_CAP    = 16;
  localparam int SUBJ_CAP    = 16;
  localparam int WORK_CAP    = CLIP_CAP + SUBJ_CAP;
  localparam int CYCLE_LIMIT = 20000000;

  // Clip model: holds both polygons and predicts the vertices of each run.
  class clip_scoreboard;
    longint    clip_x[$];
    longint    clip_y[$];
    bit        clip_done;
    longint    subj_x[$];
    longint    subj_y[$];
    bit        dropped;
    out_item_t pending[$];
    int        errors;

    function new();
      clip_done = 0;
      dropped   = 0;
      errors    = 0;
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    // Exact crossing coordinate, truncated toward zero and saturated to Q16.8.
    function longint cross_coord(longint a, longint b, longint ca, longint cb);
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] quot;
      den  = ca - cb;
      num  = 128'(signed'(a)) * den + 128'(signed'(b - a)) * 128'(signed'(ca));
      quot = num / den;
      if (quot > 128'sd8388607) return 8388607;
      if (quot < -128'sd8388608) return -8388608;
      return longint'(quot);
    endfunction

    function void keep(ref longint qx[$], ref longint qy[$], input longint x, longint y);
      if (qx.size() < WORK_CAP) begin
        qx = {qx, x};
        qy = {qy, y};
      end else begin
        dropped = 1;
      end
    endfunction

    function void clip_edge(int i, ref longint wx[$], ref longint wy[$]);
      longint nx[$];
      longint ny[$];
      longint s0x, s0y, ex, ey, lx, ly, cl, cp;
      int     k;
      k   = (i + 1 < clip_x.size()) ? i + 1 : 0;
      s0x = clip_x[i] * 256;
      s0y = clip_y[i] * 256;
      ex  = clip_x[k] - clip_x[i];
      ey  = clip_y[k] - clip_y[i];
      lx  = wx[wx.size() - 1];
      ly  = wy[wy.size() - 1];
      foreach (wx[j]) begin
        cl = (lx - s0x) * ey - (ly - s0y) * ex;
        cp = (wx[j] - s0x) * ey - (wy[j] - s0y) * ex;
        if (cp <= 0) begin
          if (cl > 0)
            keep(nx, ny, cross_coord(lx, wx[j], cl, cp), cross_coord(ly, wy[j], cl, cp));
          keep(nx, ny, wx[j], wy[j]);
        end else if (cl <= 0) begin
          keep(nx, ny, cross_coord(lx, wx[j], cl, cp), cross_coord(ly, wy[j], cl, cp));
        end
        lx = wx[j];
        ly = wy[j];
      end
      wx = nx;
      wy = ny;
    endfunction

    function void note_vertex(in_item_t it);
      longint    wx[$];
      longint    wy[$];
      out_item_t r;
      if (it.kind == KIND_CLIP) begin
        if (clip_done) begin
          clip_x.delete();
          clip_y.delete();
          clip_done = 0;
        end
        if (clip_x.size() < CLIP_CAP) begin
          clip_x = {clip_x, longint'(it.vx)};
          clip_y = {clip_y, longint'(it.vy)};
        end else begin
          dropped = 1;
        end
        if (it.final_vertex) clip_done = 1;
        return;
      end
      if (subj_x.size() < SUBJ_CAP) begin
        subj_x = {subj_x, longint'(it.vx) * 256};
        subj_y = {subj_y, longint'(it.vy) * 256};
      end else begin
        dropped = 1;
      end
      if (!it.final_vertex) return;
      wx = subj_x;
      wy = subj_y;
      for (int i = 0; i < clip_x.size() && wx.size() > 0; i++)
        clip_edge(i, wx, wy);
      if (wx.size() == 0) begin
        r = '0;
        r.end_of_polygon = 1;
        r.empty_result   = 1;
        r.overflowed     = dropped;
        pending = {pending, r};
      end else begin
        foreach (wx[j]) begin
          r.ox             = wx[j][23:0];
          r.oy             = wy[j][23:0];
          r.end_of_polygon = (j == wx.size() - 1);
          r.empty_result   = 0;
          r.overflowed     = dropped;
          pending = {pending, r};
        end
      end
      subj_x.delete();
      subj_y.delete();
      dropped = 0;
    endfunction

    function void check_vertex(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result vertex", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.ox !== want.ox) report("ox", got.ox, want.ox);
      if (got.oy !== want.oy) report("oy", got.oy, want.oy);
      if (got.end_of_polygon !== want.end_of_polygon)
        report("end_of_polygon", got.end_of_polygon, want.end_of_polygon);
      if (got.empty_result !== want.empty_result)
        report("empty_result", got.empty_result, want.empty_result);
      if (got.overflowed !== want.overflowed)
        report("overflowed", got.overflowed, want.overflowed);
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      strobe;
  out_item_t result;

  clip_scoreboard sb;
  int        cycles;
  int        sent;
  int        burst_left;
  in_item_t  poly[$];

  // Unit directions of an octagon, scaled by 1000; ascending index is counter-clockwise.
  int dir_x[8] = '{1000, 707, 0, -707, -1000, -707, 0, 707};
  int dir_y[8] = '{0, 707, 1000, 707, 0, -707, -1000, -707};

  convex_polygon_clipper u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (strobe) sb.check_vertex(result);
      if (start && !busy) sb.note_vertex(item);
    end
  end

  // Holds start through bursts and drops it for random gaps between them.
  task automatic send_vertex(logic kind, int x, int y, logic fin);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start = 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start             = 1;
    item.kind         = kind;
    item.vx           = 16'(x);
    item.vy           = 16'(y);
    item.final_vertex = fin;
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_poly(logic kind);
    foreach (poly[i])
      send_vertex(kind, poly[i].vx, poly[i].vy, i == poly.size() - 1);
  endtask

  // Builds a convex polygon from a subset of the octagon directions.
  task automatic make_convex(bit reverse, int max_r);
    int mask, r, cx, cy, lim;
    in_item_t v;
    do mask = $urandom_range(0, 255); while ($countones(mask) < 3);
    r   = $urandom_range(2, max_r);
    lim = 32767 - r;
    cx  = $urandom_range(0, 2 * lim) - lim;
    cy  = $urandom_range(0, 2 * lim) - lim;
    poly.delete();
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        v = '0;
        v.vx = 16'(cx + dir_x[i] * r / 1000);
        v.vy = 16'(cy + dir_y[i] * r / 1000);
        if (reverse) poly.push_front(v);
        else poly = {poly, v};
      end
    end
  endtask

  task automatic noise_poly(int n);
    in_item_t v;
    poly.delete();
    repeat (n) begin
      v = '0;
      v.vx = 16'($urandom);
      v.vy = 16'($urandom);
      poly = {poly, v};
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
  endtask

  initial begin
    int pick, cx, cy;
    sb         = new();
    cycles     = 0;
    sent       = 0;
    burst_left = 0;
    rst        = 1;
    start      = 0;
    item       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // No clip polygon yet: the subject passes through, extreme coordinates included.
    send_vertex(KIND_SUBJECT, -32768, -32768, 0);
    send_vertex(KIND_SUBJECT, 32767, -32768, 0);
    send_vertex(KIND_SUBJECT, 32767, 32767, 1);
    // Open clip polygon: only the loaded vertices are used.
    send_vertex(KIND_CLIP, -32768, -32768, 0);
    send_vertex(KIND_CLIP, 32767, -32768, 0);
    send_vertex(KIND_CLIP, 0, 32767, 0);
    send_vertex(KIND_SUBJECT, -30000, 0, 0);
    send_vertex(KIND_SUBJECT, 30000, 0, 0);
    send_vertex(KIND_SUBJECT, 0, 32767, 1);
    // A repeated clip vertex gives a degenerate edge; the subject misses it entirely.
    send_vertex(KIND_CLIP, 0, 0, 0);
    send_vertex(KIND_CLIP, 0, 0, 0);
    send_vertex(KIND_CLIP, 100, 0, 0);
    send_vertex(KIND_CLIP, 0, 100, 1);
    send_vertex(KIND_SUBJECT, 5000, 5000, 0);
    send_vertex(KIND_SUBJECT, 6000, 5000, 0);
    send_vertex(KIND_SUBJECT, 5000, 6000, 1);
    // Clockwise clip polygon yields an empty result.
    send_vertex(KIND_CLIP, 0, 0, 0);
    send_vertex(KIND_CLIP, 0, 100, 0);
    send_vertex(KIND_CLIP, 100, 0, 1);
    send_vertex(KIND_SUBJECT, 10, 10, 0);
    send_vertex(KIND_SUBJECT, 50, 10, 0);
    send_vertex(KIND_SUBJECT, 10, 50, 1);

    // Both stores overflow once: seventeen clip and seventeen subject vertices.
    for (int i = 0; i < 17; i++) begin
      make_convex(0, 30000);
      send_vertex(KIND_CLIP, poly[0].vx, poly[0].vy, i == 16);
    end
    noise_poly(17);
    send_poly(KIND_SUBJECT);

    while (sent < 260) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        make_convex(pick == 0, 30000);
        send_poly(KIND_CLIP);
      end
      if (pick == 9) begin
        noise_poly($urandom_range(1, 6));
        send_poly(KIND_SUBJECT);
      end else begin
        make_convex($urandom_range(0, 7) == 0, 30000);
        // Pull most subjects toward the clip polygon so that edges really cross.
        if (sb.clip_x.size() > 0 && $urandom_range(0, 3) != 0) begin
          cx = int'(sb.clip_x[0]) - int'(poly[0].vx);
          cy = int'(sb.clip_y[0]) - int'(poly[0].vy);
          foreach (poly[i]) begin
            poly[i].vx = 16'((int'(poly[i].vx) + cx) / 2);
            poly[i].vy = 16'((int'(poly[i].vy) + cy) / 2);
          end
        end
        send_poly(KIND_SUBJECT);
      end
    end

    wait_idle();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
